// ===== rtl/core/ast_pkg.sv =====
// Shared types and constants for the sleep type scanner.
// Used by ast_scan and aml_sleep_type_scanner; depends on nothing.
package ast_pkg;

    localparam logic [7:0] LEAD_NAME_OP  = 8'h08;
    localparam logic [7:0] LEAD_ROOT     = 8'h5C;
    localparam logic [7:0] CHAR_UNDER    = 8'h5F;
    localparam logic [7:0] CHAR_S        = 8'h53;
    localparam logic [7:0] CHAR_5        = 8'h35;
    localparam logic [7:0] PREFIX_BYTE   = 8'h0A;
    localparam logic [7:0] MAX_SLP_VALUE = 8'h0F;
    localparam logic [2:0] TAIL_BYTES    = 3'd4;

    typedef struct packed {
        logic       found;
        logic [3:0] type_a;
        logic [3:0] type_b;
    } result_t;

    typedef struct packed {
        logic       vld;
        logic [3:0] val;
    } cand_t;

endpackage

// ===== rtl/core/aml_sleep_type_scanner.sv =====
// Top level of the sleep type scanner: stream ports, input word register,
// result register. Depends on ast_pkg and ast_scan.
//
// Takes one block byte per cycle, back to back. Each byte is held in the
// input register while the scan state updates; the result for a block is
// written to the output register when its last byte leaves the input
// register. Input is held only when a last byte meets an output register
// whose result has not been taken yet.
module aml_sleep_type_scanner #(
    parameter int WINDOW_BYTES    = 96,
    parameter int MIN_BLOCK_BYTES = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,   // last_of_block
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [3:0] sleep_type_a, [7:4] sleep_type_b
    output logic       m_axis_tuser    // found
);

    logic              in_vld_reg;
    logic [7:0]        in_byte_reg;
    logic              in_last_reg;
    logic              out_vld_reg;
    ast_pkg::result_t  out_reg;
    ast_pkg::result_t  scan_res;
    logic              out_free;
    logic              step;

    assign out_free      = !out_vld_reg || m_axis_tready;
    assign step          = in_vld_reg && (!in_last_reg || out_free);
    assign s_axis_tready = !in_vld_reg || step;

    ast_scan #(
        .WINDOW_BYTES   (WINDOW_BYTES),
        .MIN_BLOCK_BYTES(MIN_BLOCK_BYTES)
    ) u_scan (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (step),
        .data_byte    (in_byte_reg),
        .last_of_block(in_last_reg),
        .result       (scan_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                in_vld_reg <= s_axis_tvalid;
            end
            if (step && in_last_reg) begin
                out_vld_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (step && in_last_reg) begin
            out_reg <= scan_res;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {out_reg.type_b, out_reg.type_a};
    assign m_axis_tuser  = out_reg.found;

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg && !m_axis_tready |=> out_vld_reg && $stable(out_reg))
        else $error("pending result overwritten");
    a_last_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && in_last_reg && !out_free |-> !s_axis_tready)
        else $error("input taken while last byte is blocked");
    a_ready_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_vld_reg |-> s_axis_tready)
        else $error("input stalled with empty input register");
`endif

endmodule

// ===== rtl/core/ast_scan.sv =====
// Per-byte scan state and update logic of the sleep type scanner.
// Depends on ast_pkg.
module ast_scan #(
    parameter int WINDOW_BYTES    = 96,
    parameter int MIN_BLOCK_BYTES = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [7:0]        data_byte,
    input  logic              last_of_block,
    output ast_pkg::result_t  result
);

    localparam int OFF_W = $clog2(WINDOW_BYTES + 1);
    localparam int LEN_W = $clog2(MIN_BLOCK_BYTES + 1);
    localparam logic [OFF_W-1:0] WIN_END = OFF_W'(WINDOW_BYTES);
    localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(MIN_BLOCK_BYTES);

    localparam logic [2:0] PAT_IDLE  = 3'd0;
    localparam logic [2:0] PAT_LEAD  = 3'd1;
    localparam logic [2:0] PAT_UND1  = 3'd2;
    localparam logic [2:0] PAT_S     = 3'd3;
    localparam logic [2:0] PAT_FIVE  = 3'd4;

    logic             found_reg, found_next;
    logic [3:0]       type_a_reg, type_a_next;
    logic [3:0]       type_b_reg, type_b_next;
    logic [2:0]       pat_reg, pat_next;
    logic             win_reg, win_next;
    logic [OFF_W-1:0] off_reg, off_next;
    logic             prev_reg, prev_next;
    ast_pkg::cand_t   ca_reg, ca_next;
    ast_pkg::cand_t   cb_reg, cb_next;
    logic [2:0]       bap_reg, bap_next;
    logic [LEN_W-1:0] len_reg, len_next;

    logic [2:0] restart;
    logic       match;

    always_comb begin
        restart = (data_byte == ast_pkg::LEAD_NAME_OP || data_byte == ast_pkg::LEAD_ROOT)
                  ? PAT_LEAD : PAT_IDLE;
        match = 1'b0;
        unique case (pat_reg)
            PAT_LEAD: pat_next = (data_byte == ast_pkg::CHAR_UNDER) ? PAT_UND1 : restart;
            PAT_UND1: pat_next = (data_byte == ast_pkg::CHAR_S) ? PAT_S : restart;
            PAT_S:    pat_next = (data_byte == ast_pkg::CHAR_5) ? PAT_FIVE : restart;
            PAT_FIVE: begin
                match    = (data_byte == ast_pkg::CHAR_UNDER);
                pat_next = match ? PAT_IDLE : restart;
            end
            default:  pat_next = restart;
        endcase

        found_next  = found_reg;
        type_a_next = type_a_reg;
        type_b_next = type_b_reg;
        win_next    = win_reg;
        off_next    = off_reg;
        prev_next   = prev_reg;
        ca_next     = ca_reg;
        cb_next     = cb_reg;
        bap_next    = bap_reg;
        len_next    = len_reg;

        if (step && !found_reg) begin
            if (len_reg < LEN_MIN) begin
                len_next = len_reg + 1'b1;
            end
            if (win_reg) begin
                if (bap_reg < ast_pkg::TAIL_BYTES) begin
                    bap_next = bap_reg + 1'b1;
                end
                if (prev_reg && data_byte <= ast_pkg::MAX_SLP_VALUE) begin
                    if (!ca_reg.vld) begin
                        ca_next = '{vld: 1'b1, val: data_byte[3:0]};
                    end else if (!cb_reg.vld) begin
                        cb_next = '{vld: 1'b1, val: data_byte[3:0]};
                    end
                end
                prev_next = (data_byte == ast_pkg::PREFIX_BYTE);
                off_next  = off_reg + 1'b1;
                if (off_next >= WIN_END) begin
                    win_next  = 1'b0;
                    prev_next = 1'b0;
                end
            end
            if (match && !ca_next.vld) begin
                win_next  = 1'b1;
                off_next  = '0;
                prev_next = 1'b0;
                bap_next  = '0;
                cb_next   = '0;
            end
        end else begin
            pat_next = pat_reg;
        end

        if (step && last_of_block) begin
            if (!found_reg && len_next >= LEN_MIN && ca_next.vld &&
                bap_next >= ast_pkg::TAIL_BYTES) begin
                found_next  = 1'b1;
                type_a_next = ca_next.val;
                type_b_next = cb_next.vld ? cb_next.val : ca_next.val;
            end
            pat_next  = PAT_IDLE;
            win_next  = 1'b0;
            off_next  = '0;
            prev_next = 1'b0;
            ca_next   = '0;
            cb_next   = '0;
            bap_next  = '0;
            len_next  = '0;
        end

        result.found  = found_next;
        result.type_a = found_next ? type_a_next : 4'd0;
        result.type_b = found_next ? type_b_next : 4'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg  <= 1'b0;
            type_a_reg <= '0;
            type_b_reg <= '0;
            pat_reg    <= PAT_IDLE;
            win_reg    <= 1'b0;
            off_reg    <= '0;
            prev_reg   <= 1'b0;
            ca_reg     <= '0;
            cb_reg     <= '0;
            bap_reg    <= '0;
            len_reg    <= '0;
        end else begin
            found_reg  <= found_next;
            type_a_reg <= type_a_next;
            type_b_reg <= type_b_next;
            pat_reg    <= pat_next;
            win_reg    <= win_next;
            off_reg    <= off_next;
            prev_reg   <= prev_next;
            ca_reg     <= ca_next;
            cb_reg     <= cb_next;
            bap_reg    <= bap_next;
            len_reg    <= len_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_found_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        found_reg |=> found_reg)
        else $error("found flag dropped");
    a_cand_order: assert property (@(posedge aclk) disable iff (!aresetn)
        cb_reg.vld |-> ca_reg.vld)
        else $error("type B captured before type A");
    a_tail_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        bap_reg <= ast_pkg::TAIL_BYTES)
        else $error("tail count past saturation");
    a_block_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        step && last_of_block |=> !win_reg && !ca_reg.vld && len_reg == '0)
        else $error("block state not cleared at block end");
`endif

endmodule
